// ===== hdl/pse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the stored-stream PNG encoder.
// ----------------------------------------------------------------------------
package pse_pkg;
    localparam int MaxSide = 16384;
    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [16:0] AdlerMod = 17'd65521;
    localparam logic [15:0] BlockMax = 16'hFFFF;

    // request from the sequencer to the checksum unit
    typedef struct packed {
        logic       crc_en;
        logic       crc_init;
        logic       adl_en;
        logic       adl_init;
        logic [7:0] data;
    } t_sum_req;
endpackage
`default_nettype wire

// ===== hdl/pse_sums.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_sums
// Running CRC32 and Adler-32. The CRC takes one byte a cycle as a bit-serial
// shift of eight steps on a 32-bit register; Adler adds and compares twice.
// ----------------------------------------------------------------------------
module pse_sums (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pse_pkg::t_sum_req i_req,
    output logic [31:0]            o_crc,
    output logic [31:0]            o_adler
);
    import pse_pkg::*;

    logic [31:0] r_crc, n_crc;
    logic [15:0] r_lo, r_hi, n_lo, n_hi;
    logic [16:0] s_lo, s_hi;

    always_comb begin
        n_crc = (i_req.crc_init ? 32'hFFFFFFFF : r_crc) ^ {24'd0, i_req.data};
        for (int k = 0; k < 8; k++) begin
            n_crc = n_crc[0] ? (CrcPoly ^ (n_crc >> 1)) : (n_crc >> 1);
        end
        s_lo = {1'b0, i_req.adl_init ? 16'd1 : r_lo} + {9'd0, i_req.data};
        n_lo = (s_lo >= AdlerMod) ? 16'(s_lo - AdlerMod) : s_lo[15:0];
        s_hi = {1'b0, i_req.adl_init ? 16'd0 : r_hi} + {1'b0, n_lo};
        n_hi = (s_hi >= AdlerMod) ? 16'(s_hi - AdlerMod) : s_hi[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 32'hFFFFFFFF;
            r_lo  <= 16'd1;
            r_hi  <= 16'd0;
        end else begin
            if (i_req.crc_en) begin
                r_crc <= n_crc;
            end else if (i_req.crc_init) begin
                r_crc <= 32'hFFFFFFFF;
            end
            if (i_req.adl_en) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
            end else if (i_req.adl_init) begin
                r_lo <= 16'd1;
                r_hi <= 16'd0;
            end
        end
    end

    assign o_crc   = ~r_crc;
    assign o_adler = {r_hi, r_lo};
endmodule
`default_nettype wire

// ===== hdl/png_stored_stream_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// png_stored_stream_encoder
// RGBA8 PNG writer using stored deflate blocks, one byte per cycle.
// ----------------------------------------------------------------------------
// One output byte per cycle when i_ready is high. A start beat with no image
// open produces 48 bytes, a pixel 4 or 5 plus 5 per stored-block header crossed,
// and the last pixel 20 more. The next beat is taken once the last byte of the
// current one is in the output register. IDAT length is formed by a serial
// shift-add multiply and a short block count in ST_CALC after a start beat,
// before its bytes leave.
module png_stored_stream_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_pixel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_file_end,
    output logic             o_run_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pse_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_HDR  = 3'd2;
    localparam logic [2:0] ST_PIX  = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;

    logic [14:0] r_cfg_w, r_cfg_h;
    logic [2:0]  r_st;
    logic        r_open;
    logic [14:0] r_w, r_h, r_col, r_row;
    logic [31:0] r_raw_left;
    logic [15:0] r_blk_left;
    logic [31:0] r_px;
    logic [5:0]  r_idx;
    logic        r_need_f;
    logic [2:0]  r_pb;
    logic [2:0]  r_hb;
    logic        r_inblk;
    logic        r_last;
    logic [31:0] r_raw, r_acc, r_idat;
    logic [6:0]  r_cnt;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_of, r_or;

    t_sum_req    s_req;
    logic [31:0] s_crc, s_adler;
    logic        s_adv;
    logic        s_emit;
    logic [7:0]  s_byte;
    logic        s_fe, s_re;
    logic [15:0] s_len;
    logic [16:0] s_qr, s_blocks;

    assign pready = 1'b1;
    assign prdata = (paddr[2] ? {17'd0, r_cfg_h} : {17'd0, r_cfg_w});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 15'd1;
            r_cfg_h <= 15'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr == 3'd0) r_cfg_w <= pwdata[14:0];
            else if (paddr == 3'd4) r_cfg_h <= pwdata[14:0];
        end
    end

    pse_sums u_sums (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (s_req),
        .o_crc  (s_crc),
        .o_adler(s_adler)
    );

    assign o_ready = (r_st == ST_IDLE);
    assign s_adv   = !r_ov || i_ready;
    assign s_emit  = s_adv && (r_st == ST_HDR || r_st == ST_PIX || r_st == ST_TAIL);
    assign s_len   = (r_raw_left > 32'd65535) ? BlockMax : r_raw_left[15:0];

    // blocks = ceil(raw / 65535), using 65536*q + r = 65535*q + (q + r)
    assign s_qr     = {1'b0, r_raw[31:16]} + {1'b0, r_raw[15:0]};
    assign s_blocks = {1'b0, r_raw[31:16]} + ((s_qr == 17'd0) ? 17'd0 :
                      (s_qr > 17'd65535) ? 17'd2 : 17'd1);

    function automatic logic [14:0] clamp(input logic [14:0] v);
        if (v == 15'd0) return 15'd1;
        if (v > 15'(MaxSide)) return 15'(MaxSide);
        return v;
    endfunction

    function automatic logic [7:0] be(input logic [31:0] v, input logic [1:0] i);
        unique case (i)
            2'd0:    return v[31:24];
            2'd1:    return v[23:16];
            2'd2:    return v[15:8];
            default: return v[7:0];
        endcase
    endfunction

    // byte of the block header under r_hb
    function automatic logic [7:0] hdrb(input logic [2:0] i, input logic fin,
                                        input logic [15:0] l);
        unique case (i)
            3'd0:    return {7'd0, fin};
            3'd1:    return l[7:0];
            3'd2:    return l[15:8];
            3'd3:    return ~l[7:0];
            default: return ~l[15:8];
        endcase
    endfunction

    // emission logic: decides this cycle's byte and checksum action
    always_comb begin
        s_req  = '0;
        s_byte = 8'd0;
        s_fe   = 1'b0;
        s_re   = 1'b0;
        if (r_inblk) begin
            s_byte = hdrb(r_hb, r_raw_left <= 32'd65535, s_len);
            s_req.crc_en = 1'b1;
            s_re = (r_hb == 3'd4) && (r_st == ST_HDR ||
                   (r_st == ST_PIX && r_pb == 3'd4 && !r_last));
        end else if (r_st == ST_HDR) begin
            unique case (r_idx)
                6'd0: s_byte = 8'd137;  6'd1: s_byte = 8'd80;
                6'd2: s_byte = 8'd78;   6'd3: s_byte = 8'd71;
                6'd4: s_byte = 8'd13;   6'd5: s_byte = 8'd10;
                6'd6: s_byte = 8'd26;   6'd7: s_byte = 8'd10;
                6'd8, 6'd9, 6'd10: s_byte = 8'd0;
                6'd11: s_byte = 8'd13;
                6'd12: s_byte = "I";  6'd13: s_byte = "H";
                6'd14: s_byte = "D";  6'd15: s_byte = "R";
                6'd16, 6'd17, 6'd18, 6'd19: s_byte = be({17'd0, r_w}, r_idx[1:0]);
                6'd20, 6'd21, 6'd22, 6'd23: s_byte = be({17'd0, r_h}, r_idx[1:0]);
                6'd24: s_byte = 8'd8;
                6'd25: s_byte = 8'd6;
                6'd26, 6'd27, 6'd28: s_byte = 8'd0;
                6'd29, 6'd30, 6'd31, 6'd32: s_byte = be(s_crc, r_idx[1:0] - 2'd1);
                6'd33, 6'd34, 6'd35, 6'd36: s_byte = be(r_idat, r_idx[1:0] - 2'd1);
                6'd37: s_byte = "I";  6'd38: s_byte = "D";
                6'd39: s_byte = "A";  6'd40: s_byte = "T";
                6'd41: s_byte = 8'h78;
                default: s_byte = 8'h01;
            endcase
            s_req.crc_init = (r_idx == 6'd12) || (r_idx == 6'd37);
            s_req.crc_en   = (r_idx >= 6'd12 && r_idx <= 6'd28) || r_idx >= 6'd37;
            s_req.adl_init = (r_idx == 6'd42);
        end else if (r_st == ST_PIX) begin
            s_byte = r_need_f ? 8'd0 : be(r_px, r_pb[1:0]);
            s_req.crc_en = 1'b1;
            s_req.adl_en = 1'b1;
            s_re = !r_need_f && r_pb == 3'd3 && !r_last && !(r_blk_left == 16'd1
                   && r_raw_left > 32'd1);
        end else if (r_st == ST_TAIL) begin
            unique case (r_idx[4:2])
                3'd0:    s_byte = be(s_adler, r_idx[1:0]);
                3'd1:    s_byte = be(s_crc, r_idx[1:0]);
                3'd2:    s_byte = 8'd0;
                3'd3:    s_byte = (r_idx[1:0] == 2'd0) ? "I" : (r_idx[1:0] == 2'd1) ? "E"
                                  : (r_idx[1:0] == 2'd2) ? "N" : "D";
                default: s_byte = be(s_crc, r_idx[1:0]);
            endcase
            s_req.crc_en   = (r_idx < 6'd4) || (r_idx >= 6'd12 && r_idx < 6'd16);
            s_req.crc_init = (r_idx == 6'd12);
            s_fe = (r_idx == 6'd19);
            s_re = s_fe;
        end
        s_req.data = s_byte;
        if (!s_adv || r_st == ST_IDLE || r_st == ST_CALC) begin
            s_req = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_open <= 1'b0;
            r_ov   <= 1'b0;
            r_inblk <= 1'b0;
            r_w <= 15'd1;
            r_h <= 15'd1;
        end else begin
            if (s_emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (!i_kind && !r_open) begin
                            r_w <= clamp(r_cfg_w);
                            r_h <= clamp(r_cfg_h);
                            r_acc <= 32'd0;
                            r_cnt <= 7'd0;
                            r_st <= ST_CALC;
                        end else if (i_kind && r_open) begin
                            r_px <= i_pixel;
                            r_need_f <= (r_col == 15'd0);
                            r_pb <= 3'd0;
                            r_last <= (r_col + 15'd1 >= r_w) && (r_row + 15'd1 >= r_h);
                            r_st <= ST_PIX;
                        end
                    end
                end
                ST_CALC: begin
                    // raw = (4w+1)*h by shift-add, then the block count
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt < 7'd15) begin
                        if (r_h[r_cnt[3:0]])
                            r_acc <= r_acc + ({15'd0, r_w, 2'b01} << r_cnt[3:0]);
                    end else if (r_cnt == 7'd15) begin
                        r_raw <= r_acc;
                        r_idat <= r_acc + 32'd6;
                    end else if (r_cnt == 7'd16) begin
                        r_idat <= r_idat + {13'd0, s_blocks, 2'b00} + {15'd0, s_blocks};
                    end else begin
                        r_raw_left <= r_raw;
                        r_col <= 15'd0;
                        r_row <= 15'd0;
                        r_idx <= 6'd0;
                        r_st  <= ST_HDR;
                    end
                end
                ST_HDR: begin
                    if (s_adv) begin
                        r_ob <= s_byte;
                        r_of <= 1'b0;
                        r_or <= s_re;
                        if (r_inblk) begin
                            r_hb <= r_hb + 3'd1;
                            if (r_hb == 3'd4) begin
                                r_inblk <= 1'b0;
                                r_blk_left <= s_len;
                                r_open <= 1'b1;
                                r_st <= ST_IDLE;
                            end
                        end else begin
                            r_idx <= r_idx + 6'd1;
                            if (r_idx == 6'd42) begin
                                r_inblk <= 1'b1;
                                r_hb <= 3'd0;
                            end
                        end
                    end
                end
                ST_PIX: begin
                    if (s_adv) begin
                        r_ob <= s_byte;
                        r_of <= 1'b0;
                        r_or <= s_re;
                        if (r_inblk) begin
                            r_hb <= r_hb + 3'd1;
                            if (r_hb == 3'd4) begin
                                r_inblk <= 1'b0;
                                r_blk_left <= s_len;
                                if (r_pb == 3'd4) r_st <= ST_IDLE;
                            end
                        end else begin
                            r_raw_left <= r_raw_left - 32'd1;
                            r_blk_left <= r_blk_left - 16'd1;
                            if (r_blk_left == 16'd1 && r_raw_left > 32'd1) begin
                                r_inblk <= 1'b1;
                                r_hb <= 3'd0;
                            end
                            if (r_need_f) begin
                                r_need_f <= 1'b0;
                            end else begin
                                r_pb <= r_pb + 3'd1;
                                if (r_pb == 3'd3) begin
                                    if (r_col + 15'd1 >= r_w) begin
                                        r_col <= 15'd0;
                                        r_row <= r_row + 15'd1;
                                    end else begin
                                        r_col <= r_col + 15'd1;
                                    end
                                    if (r_last) begin
                                        r_idx <= 6'd0;
                                        r_open <= 1'b0;
                                        r_st <= ST_TAIL;
                                    end else if (!(r_blk_left == 16'd1 &&
                                                   r_raw_left > 32'd1)) begin
                                        r_st <= ST_IDLE;
                                    end
                                end
                            end
                        end
                    end
                end
                ST_TAIL: begin
                    if (s_adv) begin
                        r_ob <= s_byte;
                        r_of <= s_fe;
                        r_or <= s_re;
                        r_idx <= r_idx + 6'd1;
                        if (r_idx == 6'd19) r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ov;
    assign o_out_byte = r_ob;
    assign o_file_end = r_of;
    assign o_run_end  = r_or;

    a_file_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_file_end |-> o_run_end) else $error("file end without run end");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_IDLE |-> !o_ready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte))
        else $error("output beat dropped");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stored-stream PNG encoder. A directed table
// walks the idle, open and done states, size clamping and small images, then
// random images with interleaved out-of-place beats follow. Every output byte
// is compared with a behavioral predictor of the file layout and checksums.
// ----------------------------------------------------------------------------
module tb;
    typedef enum int {ROW_ITEM, ROW_CFG} t_row_op;
    typedef enum int {REG_WIDTH = 0, REG_HEIGHT = 1} t_reg_idx;
    typedef enum int {PH_IDLE, PH_STREAM, PH_DONE} t_phase;
    localparam bit KIND_START = 1'b0;
    localparam bit KIND_PIXEL = 1'b1;
    localparam int WatchLimit = 4000;
    localparam int Drain = 150;

    typedef struct {
        bit [7:0] data;
        bit       file_end;
        bit       run_end;
    } t_png_byte;

    typedef struct {
        t_row_op     op;
        bit          kind;
        bit [31:0]   val;
        int          n_bytes;
        int          first_b;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_kind = 1'b0;
    logic [31:0] i_pixel = '0;
    logic        i_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_ready, o_valid, o_file_end, o_run_end, pready;
    logic [7:0]  o_out_byte;
    logic [31:0] prdata;

    png_stored_stream_encoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_kind(i_kind), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_ready(i_ready), .o_out_byte(o_out_byte),
        .o_file_end(o_file_end), .o_run_end(o_run_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    bit [14:0]   cfg_width = 15'd1, cfg_height = 15'd1;
    t_phase      enc_phase = PH_IDLE;
    bit [31:0]   run_crc = 32'hFFFFFFFF;
    int unsigned adl_lo = 1, adl_hi = 0, col_cnt = 0, row_cnt = 0;
    int unsigned blk_left = 0, raw_left = 0, cur_w = 1, cur_h = 1;
    t_png_byte   file_q[$];

    int  err_cnt = 0;
    int  quiet_cycles = 0;
    bit  idle_en = 1'b1;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic bit [31:0] crc_next(bit [31:0] c, bit [7:0] b);
        c ^= {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function void put_byte(bit [7:0] b, bit hashed);
        t_png_byte e;
        if (hashed) run_crc = crc_next(run_crc, b);
        e.data = b;
        e.file_end = 1'b0;
        e.run_end = 1'b0;
        file_q.push_back(e);
    endfunction

    function void put_be32(bit [31:0] v, bit hashed);
        for (int i = 3; i >= 0; i--) put_byte(v[8*i +: 8], hashed);
    endfunction

    function int unsigned side_clamp(bit [14:0] v);
        if (v == 15'd0) return 1;
        if (v > 15'd16384) return 16384;
        return {17'd0, v};
    endfunction

    function void open_block();
        bit [15:0] len, inv;
        len = (raw_left > 65535) ? 16'hFFFF : raw_left[15:0];
        inv = ~len;
        put_byte({7'd0, raw_left <= 65535}, 1'b1);
        put_byte(len[7:0], 1'b1);
        put_byte(len[15:8], 1'b1);
        put_byte(inv[7:0], 1'b1);
        put_byte(inv[15:8], 1'b1);
        blk_left = {16'd0, len};
    endfunction

    function void put_raw(bit [7:0] b);
        put_byte(b, 1'b1);
        adl_lo = (adl_lo + b) % 65521;
        adl_hi = (adl_hi + adl_lo) % 65521;
        if (blk_left > 0) blk_left--;
        if (raw_left > 0) raw_left--;
        if (blk_left == 0 && raw_left > 0) open_block();
    endfunction

    function void start_png();
        longint raw, blocks;
        cur_w = side_clamp(cfg_width);
        cur_h = side_clamp(cfg_height);
        raw = (longint'(cur_w) * 4 + 1) * longint'(cur_h);
        blocks = (raw + 65534) / 65535;
        put_be32(32'h89504E47, 1'b0);
        put_be32(32'h0D0A1A0A, 1'b0);
        put_be32(32'd13, 1'b0);
        run_crc = 32'hFFFFFFFF;
        put_be32(32'h49484452, 1'b1);
        put_be32(cur_w, 1'b1);
        put_be32(cur_h, 1'b1);
        put_byte(8'd8, 1'b1);
        put_byte(8'd6, 1'b1);
        put_byte(8'd0, 1'b1);
        put_byte(8'd0, 1'b1);
        put_byte(8'd0, 1'b1);
        put_be32(~run_crc, 1'b0);
        put_be32(32'(2 + raw + blocks * 5 + 4), 1'b0);
        run_crc = 32'hFFFFFFFF;
        put_be32(32'h49444154, 1'b1);
        put_byte(8'h78, 1'b1);
        put_byte(8'h01, 1'b1);
        adl_lo = 1;
        adl_hi = 0;
        col_cnt = 0;
        row_cnt = 0;
        raw_left = 32'(raw);
        blk_left = 0;
        open_block();
        enc_phase = PH_STREAM;
    endfunction

    function void finish_png();
        put_be32({adl_hi[15:0], adl_lo[15:0]}, 1'b1);
        put_be32(~run_crc, 1'b0);
        put_be32(32'd0, 1'b0);
        run_crc = 32'hFFFFFFFF;
        put_be32(32'h49454E44, 1'b1);
        put_be32(~run_crc, 1'b0);
        file_q[file_q.size()-1].file_end = 1'b1;
        enc_phase = PH_DONE;
    endfunction

    function void take_pixel(bit [31:0] px);
        if (col_cnt == 0) put_raw(8'd0);
        put_raw(px[31:24]);
        put_raw(px[23:16]);
        put_raw(px[15:8]);
        put_raw(px[7:0]);
        if (col_cnt + 1 >= cur_w) begin
            col_cnt = 0;
            if (row_cnt + 1 >= cur_h) begin
                row_cnt = 0;
                finish_png();
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endfunction

    function int predict_beat(bit kind, bit [31:0] px);
        int n0;
        n0 = file_q.size();
        if (kind == KIND_START) begin
            if (enc_phase != PH_STREAM) start_png();
        end else if (enc_phase == PH_STREAM) begin
            take_pixel(px);
        end
        if (file_q.size() > n0) file_q[file_q.size()-1].run_end = 1'b1;
        return file_q.size() - n0;
    endfunction

    function int draw_gap();
        if (!idle_en || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    task automatic send_beat(input bit kind, input bit [31:0] px,
                             output int n, output int first_b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind = kind;
        i_pixel = px;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        n = predict_beat(kind, px);
        first_b = (n > 0) ? file_q[file_q.size()-n].data : -1;
        @(negedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input bit [2:0] addr, input bit [31:0] wdata,
                              output bit [31:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_reg(input t_reg_idx idx, input bit [31:0] val);
        bit [31:0] rd;
        apb_access(1'b1, 3'(4 * idx), val, rd);
        if (idx == REG_WIDTH) cfg_width = val[14:0];
        else cfg_height = val[14:0];
        apb_access(1'b0, 3'(4 * idx), 32'd0, rd);
        if (rd[14:0] != val[14:0])
            report($sformatf("reg %0d read %h, wrote %h", idx, rd, val));
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (file_q.size() != 0) @(negedge i_clk);
        repeat (Drain) @(negedge i_clk);
    endtask

    // sink with random stalls
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (file_q.size() == 0) begin
                report($sformatf("unexpected byte %h", o_out_byte));
            end else begin
                if (o_out_byte != file_q[0].data || o_file_end != file_q[0].file_end ||
                    o_run_end != file_q[0].run_end)
                    report($sformatf("got %h fe%0d re%0d, want %h fe%0d re%0d",
                        o_out_byte, o_file_end, o_run_end, file_q[0].data,
                        file_q[0].file_end, file_q[0].run_end));
                void'(file_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((o_valid && i_ready) || (i_valid && o_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    t_row dir_tbl[] = '{
        '{ROW_ITEM, KIND_PIXEL,      32'h0,        0,  -1},
        '{ROW_ITEM, KIND_START,      32'h0,        48, 137},
        '{ROW_ITEM, KIND_START,      32'h0,        0,  -1},
        '{ROW_ITEM, KIND_PIXEL,      32'hFFFFFFFF, 25, 0},
        '{ROW_ITEM, KIND_PIXEL,      32'h0,        0,  -1},
        '{ROW_CFG,  1'(REG_WIDTH),   32'h0,        -1, -1},
        '{ROW_CFG,  1'(REG_HEIGHT),  32'h0,        -1, -1},
        '{ROW_ITEM, KIND_START,      32'hFFFFFFFF, 48, 137},
        '{ROW_ITEM, KIND_PIXEL,      32'h00000000, 25, 0},
        '{ROW_CFG,  1'(REG_WIDTH),   32'd2,        -1, -1},
        '{ROW_CFG,  1'(REG_HEIGHT),  32'd2,        -1, -1},
        '{ROW_ITEM, KIND_START,      32'h0,        48, 137},
        '{ROW_ITEM, KIND_PIXEL,      32'h80000001, 5,  0},
        '{ROW_ITEM, KIND_START,      32'h0,        0,  -1},
        '{ROW_ITEM, KIND_PIXEL,      32'h7FFFFFFE, 4,  -1},
        '{ROW_ITEM, KIND_PIXEL,      32'h12345678, 5,  0},
        '{ROW_ITEM, KIND_PIXEL,      32'hA5A5A5A5, 24, -1},
        '{ROW_CFG,  1'(REG_WIDTH),   32'd3,        -1, -1},
        '{ROW_CFG,  1'(REG_HEIGHT),  32'd1,        -1, -1},
        '{ROW_ITEM, KIND_START,      32'h0,        48, 137},
        '{ROW_ITEM, KIND_PIXEL,      32'h5A5A5A5A, 5,  0},
        '{ROW_ITEM, KIND_PIXEL,      32'hC3C3C33C, 4,  -1},
        '{ROW_ITEM, KIND_PIXEL,      32'h00FF00FF, 24, -1}
    };

    initial begin
        int n, fb, w, h, sent;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].op == ROW_CFG) begin
                wait_idle();
                set_reg(t_reg_idx'(dir_tbl[i].kind), dir_tbl[i].val);
            end else begin
                send_beat(dir_tbl[i].kind, dir_tbl[i].val, n, fb);
                if (n != dir_tbl[i].n_bytes || (dir_tbl[i].first_b >= 0 && fb != dir_tbl[i].first_b))
                    report($sformatf("row %0d: %0d bytes first %0d", i, n, fb));
            end
        end

        sent = 0;
        while (sent < 220) begin
            wait_idle();
            idle_en = ($urandom_range(0, 3) != 0);
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
            h = $urandom_range(1, 4);
            set_reg(REG_WIDTH, {$urandom} & 32'hFFFF8000 | 32'(w));
            set_reg(REG_HEIGHT, {$urandom} & 32'hFFFF8000 | 32'(h));
            if ($urandom_range(0, 3) == 0) begin
                send_beat(KIND_PIXEL, $urandom, n, fb);
                sent++;
            end
            send_beat(KIND_START, $urandom, n, fb);
            sent++;
            for (int p = 0; p < w * h; p++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(KIND_START, $urandom, n, fb);
                    sent++;
                end
                send_beat(KIND_PIXEL, $urandom, n, fb);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                send_beat(KIND_PIXEL, $urandom, n, fb);
                sent++;
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/pse_pkg.sv
hdl/pse_sums.sv
hdl/png_stored_stream_encoder.sv
verif/tb.sv
